// ----- rtl/core/stg_pkg.sv -----
// ----------------------------------------------------------------------------
// stg_pkg: shared types and constants of the sine tone generator
// Request and result payloads, sequencer codes, control structs and the
// quarter-free full-period sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

	// Field widths fixed by the payload definition.
	localparam int PHASE_W  = 24;
	localparam int DUR_W    = 16;
	localparam int REM_W    = 22;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 15;
	localparam int ROM_AW   = 8;

	// Shared multiplier operand and product widths.
	localparam int MUL_W  = 30;
	localparam int PROD_W = 60;

	// A fade numerator is below 32767 * 63 < 2^21.
	localparam int FADE_NUM_W = 21;

	// Milliseconds to samples: divide by 1000 as a shift by 3 and then a
	// reciprocal multiply for 125 over a 29-bit numerator.
	localparam int MS_PRE_SHIFT = 3;
	localparam int MS_SHIFT     = 36;
	localparam logic [MUL_W-1:0] MS_RECIP = 30'd549755814;

	// Request and result payloads.
	typedef struct packed {
		logic               req_type;
		logic [PHASE_W-1:0] phase_step;
		logic [DUR_W-1:0]   duration_ms;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       playing;
		logic                       last;
	} res_t;

	// Request type codes.
	localparam logic REQ_FILL  = 1'b0;
	localparam logic REQ_START = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START_MUL,
		ST_START_DIV,
		ST_START_DONE,
		ST_NOTE,
		ST_LOOK,
		ST_FI_MUL,
		ST_FI_DIV,
		ST_FO_MUL,
		ST_FO_DIV,
		ST_EMIT
	} state_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_DUR,
		MUL_MS,
		MUL_FADE_IN,
		MUL_FADE_OUT,
		MUL_RECIP
	} mul_op_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic req_valid;
		logic req_start;
		logic rem_zero;
		logic out_free;
		logic fade_in;
		logic fade_out;
		logic pos_last;
	} status_t;

	// Sequencer commands to the datapath.
	typedef struct packed {
		logic    req_ready;
		logic    take_start;
		logic    mul_en;
		mul_op_t mul_op;
		logic    lookup;
		logic    div_step;
		logic    emit_sample;
		logic    emit_idle;
		logic    start_done;
	} ctrl_t;

	// One full period of round(32767 * sin(2 * pi * k / 256)).
	localparam logic signed [SAMPLE_W-1:0] SINE_ROM [256] = '{
		16'sd0, 16'sd804, 16'sd1608, 16'sd2410, 16'sd3212, 16'sd4011, 16'sd4808,
		16'sd5602, 16'sd6393, 16'sd7179, 16'sd7962, 16'sd8739, 16'sd9512,
		16'sd10278, 16'sd11039, 16'sd11793, 16'sd12539, 16'sd13279, 16'sd14010,
		16'sd14732, 16'sd15446, 16'sd16151, 16'sd16846, 16'sd17530, 16'sd18204,
		16'sd18868, 16'sd19519, 16'sd20159, 16'sd20787, 16'sd21403, 16'sd22005,
		16'sd22594, 16'sd23170, 16'sd23731, 16'sd24279, 16'sd24811, 16'sd25329,
		16'sd25832, 16'sd26319, 16'sd26790, 16'sd27245, 16'sd27683, 16'sd28105,
		16'sd28510, 16'sd28898, 16'sd29268, 16'sd29621, 16'sd29956, 16'sd30273,
		16'sd30571, 16'sd30852, 16'sd31113, 16'sd31356, 16'sd31580, 16'sd31785,
		16'sd31971, 16'sd32137, 16'sd32285, 16'sd32412, 16'sd32521, 16'sd32609,
		16'sd32678, 16'sd32728, 16'sd32757, 16'sd32767, 16'sd32757, 16'sd32728,
		16'sd32678, 16'sd32609, 16'sd32521, 16'sd32412, 16'sd32285, 16'sd32137,
		16'sd31971, 16'sd31785, 16'sd31580, 16'sd31356, 16'sd31113, 16'sd30852,
		16'sd30571, 16'sd30273, 16'sd29956, 16'sd29621, 16'sd29268, 16'sd28898,
		16'sd28510, 16'sd28105, 16'sd27683, 16'sd27245, 16'sd26790, 16'sd26319,
		16'sd25832, 16'sd25329, 16'sd24811, 16'sd24279, 16'sd23731, 16'sd23170,
		16'sd22594, 16'sd22005, 16'sd21403, 16'sd20787, 16'sd20159, 16'sd19519,
		16'sd18868, 16'sd18204, 16'sd17530, 16'sd16846, 16'sd16151, 16'sd15446,
		16'sd14732, 16'sd14010, 16'sd13279, 16'sd12539, 16'sd11793, 16'sd11039,
		16'sd10278, 16'sd9512, 16'sd8739, 16'sd7962, 16'sd7179, 16'sd6393,
		16'sd5602, 16'sd4808, 16'sd4011, 16'sd3212, 16'sd2410, 16'sd1608,
		16'sd804, 16'sd0, -16'sd804, -16'sd1608, -16'sd2410, -16'sd3212,
		-16'sd4011, -16'sd4808, -16'sd5602, -16'sd6393, -16'sd7179, -16'sd7962,
		-16'sd8739, -16'sd9512, -16'sd10278, -16'sd11039, -16'sd11793,
		-16'sd12539, -16'sd13279, -16'sd14010, -16'sd14732, -16'sd15446,
		-16'sd16151, -16'sd16846, -16'sd17530, -16'sd18204, -16'sd18868,
		-16'sd19519, -16'sd20159, -16'sd20787, -16'sd21403, -16'sd22005,
		-16'sd22594, -16'sd23170, -16'sd23731, -16'sd24279, -16'sd24811,
		-16'sd25329, -16'sd25832, -16'sd26319, -16'sd26790, -16'sd27245,
		-16'sd27683, -16'sd28105, -16'sd28510, -16'sd28898, -16'sd29268,
		-16'sd29621, -16'sd29956, -16'sd30273, -16'sd30571, -16'sd30852,
		-16'sd31113, -16'sd31356, -16'sd31580, -16'sd31785, -16'sd31971,
		-16'sd32137, -16'sd32285, -16'sd32412, -16'sd32521, -16'sd32609,
		-16'sd32678, -16'sd32728, -16'sd32757, -16'sd32767, -16'sd32757,
		-16'sd32728, -16'sd32678, -16'sd32609, -16'sd32521, -16'sd32412,
		-16'sd32285, -16'sd32137, -16'sd31971, -16'sd31785, -16'sd31580,
		-16'sd31356, -16'sd31113, -16'sd30852, -16'sd30571, -16'sd30273,
		-16'sd29956, -16'sd29621, -16'sd29268, -16'sd28898, -16'sd28510,
		-16'sd28105, -16'sd27683, -16'sd27245, -16'sd26790, -16'sd26319,
		-16'sd25832, -16'sd25329, -16'sd24811, -16'sd24279, -16'sd23731,
		-16'sd23170, -16'sd22594, -16'sd22005, -16'sd21403, -16'sd20787,
		-16'sd20159, -16'sd19519, -16'sd18868, -16'sd18204, -16'sd17530,
		-16'sd16846, -16'sd16151, -16'sd15446, -16'sd14732, -16'sd14010,
		-16'sd13279, -16'sd12539, -16'sd11793, -16'sd11039, -16'sd10278,
		-16'sd9512, -16'sd8739, -16'sd7962, -16'sd7179, -16'sd6393, -16'sd5602,
		-16'sd4808, -16'sd4011, -16'sd3212, -16'sd2410, -16'sd1608, -16'sd804
	};

endpackage

`default_nettype wire

// ----- rtl/core/stg_stream_if.sv -----
// ----------------------------------------------------------------------------
// stg_stream_if: valid/ready stream channel
// Carries one payload item per transfer; the payload type is a parameter.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/stg_mul.sv -----
// ----------------------------------------------------------------------------
// stg_mul: shared unsigned multiplier
// One 30 x 30 multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_mul (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [stg_pkg::MUL_W-1:0]  a,
	input  wire logic [stg_pkg::MUL_W-1:0]  b,
	output logic      [stg_pkg::PROD_W-1:0] prod_q
);

	import stg_pkg::*;

	// The product holds until the next enabled cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/stg_seq.sv -----
// ----------------------------------------------------------------------------
// stg_seq: request sequencer
// Steps a start request through the duration conversion and a fill request through lookup,
// fades and output of each sample, or to one not-playing result once the tone has run out.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stg_pkg::status_t status,
	output stg_pkg::ctrl_t        ctrl
);

	import stg_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.req_valid) begin
					if (status.req_start) begin
						state_d = ST_START_MUL;
					end else if (status.rem_zero) begin
						state_d = ST_NOTE;
					end else begin
						state_d = ST_LOOK;
					end
				end
			end
			ST_START_MUL:  state_d = ST_START_DIV;
			ST_START_DIV:  state_d = ST_START_DONE;
			ST_START_DONE: state_d = ST_IDLE;
			ST_NOTE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOOK: begin
				if (status.fade_in) begin
					state_d = ST_FI_MUL;
				end else if (status.fade_out) begin
					state_d = ST_FO_MUL;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_FI_MUL: state_d = ST_FI_DIV;
			ST_FI_DIV: begin
				state_d = status.fade_out ? ST_FO_MUL : ST_EMIT;
			end
			ST_FO_MUL: state_d = ST_FO_DIV;
			ST_FO_DIV: state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = status.pos_last ? ST_IDLE : ST_LOOK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands of each state.
	always_comb begin
		ctrl = '{
			req_ready:   1'b0,
			take_start:  1'b0,
			mul_en:      1'b0,
			mul_op:      MUL_DUR,
			lookup:      1'b0,
			div_step:    1'b0,
			emit_sample: 1'b0,
			emit_idle:   1'b0,
			start_done:  1'b0
		};
		unique case (state_q)
			ST_IDLE: begin
				ctrl.req_ready  = 1'b1;
				ctrl.take_start = status.req_valid && status.req_start;
			end
			ST_START_MUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = MUL_DUR;
			end
			ST_START_DIV: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = MUL_MS;
			end
			ST_START_DONE: ctrl.start_done = 1'b1;
			ST_NOTE:       ctrl.emit_idle = status.out_free;
			ST_LOOK:       ctrl.lookup = 1'b1;
			ST_FI_MUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = MUL_FADE_IN;
			end
			ST_FI_DIV, ST_FO_DIV: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_op   = MUL_RECIP;
				ctrl.div_step = 1'b1;
			end
			ST_FO_MUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = MUL_FADE_OUT;
			end
			ST_EMIT: ctrl.emit_sample = status.out_free;
			default: ctrl.req_ready = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/sine_tone_generator_with_fades.sv -----
// ----------------------------------------------------------------------------
// sine_tone_generator_with_fades: DDS sine tone generator with fades
// Phase accumulator, sine table lookup and linear fade in and fade out,
// all products and divisions through one shared multiplier.
// ----------------------------------------------------------------------------
// A start request (req_type 1) stores the phase step and converts the
// duration to a sample count; it produces no result. A fill request
// (req_type 0) produces BUFFER_SAMPLES results, the last one flagged, or a
// single not-playing result when the tone has run out. Each sample passes
// through a phase step with table lookup, then output, with a multiply and
// a division step for each fade that applies to its buffer. The single
// registered multiplier performs every fade product and every division by
// reciprocal, one operation per cycle; a stalled result port holds the
// sequence.
// The request port is ready only between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_generator_with_fades #(
	parameter int BUFFER_SAMPLES = 64,
	parameter int SAMPLE_RATE    = 48000
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	stg_stream_if.sink   req,
	stg_stream_if.source res
);

	import stg_pkg::*;

	localparam int POS_W      = $clog2(BUFFER_SAMPLES);
	localparam int FADE_SHIFT = FADE_NUM_W + $clog2(BUFFER_SAMPLES);
	localparam logic [MUL_W-1:0] RECIP_B = MUL_W'(((64'd1 << FADE_SHIFT) +
		64'(BUFFER_SAMPLES) - 64'd1) / 64'(BUFFER_SAMPLES));
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUFFER_SAMPLES - 1);

	status_t status;
	ctrl_t   ctrl;

	// Tone state.
	logic [PHASE_W-1:0] acc_q;
	logic [PHASE_W-1:0] inc_q;
	logic [REM_W-1:0]   rem_q;
	logic               first_q;
	logic [POS_W-1:0]   pos_q;
	logic               from_div_q;
	logic               out_valid_q;

	// Payload registers.
	logic [DUR_W-1:0] dur_q;
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	res_t             out_q;

	// Shared multiplier operands.
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;

	logic [PHASE_W-1:0]         phase_next;
	logic signed [SAMPLE_W-1:0] rom_val;
	logic [SAMPLE_W-1:0]        rom_abs;
	logic [MAG_W-1:0]           mag_now;
	logic                       ending;
	logic                       out_free;

	// Status for the sequencer.
	assign ending   = rem_q <= REM_W'(BUFFER_SAMPLES);
	assign out_free = !out_valid_q || res.ready;

	assign status = '{
		req_valid: req.valid,
		req_start: req.data.req_type == REQ_START,
		rem_zero:  rem_q == '0,
		out_free:  out_free,
		fade_in:   first_q,
		fade_out:  ending,
		pos_last:  pos_q == LAST_POS
	};

	stg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Table lookup at the advanced phase.
	assign phase_next = acc_q + inc_q;
	assign rom_val    = SINE_ROM[phase_next[PHASE_W-1 -: ROM_AW]];
	assign rom_abs    = rom_val[SAMPLE_W-1] ? SAMPLE_W'(-rom_val) : SAMPLE_W'(rom_val);

	// The working magnitude is the last quotient once a fade has run.
	assign mag_now = from_div_q ? prod[FADE_SHIFT +: MAG_W] : mag_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (ctrl.mul_op)
			MUL_DUR: begin
				mul_a = MUL_W'(dur_q);
				mul_b = MUL_W'(SAMPLE_RATE);
			end
			MUL_MS: begin
				mul_a = MUL_W'(prod[31:MS_PRE_SHIFT]);
				mul_b = MS_RECIP;
			end
			MUL_FADE_IN: begin
				mul_a = MUL_W'(mag_now);
				mul_b = MUL_W'(pos_q);
			end
			MUL_FADE_OUT: begin
				mul_a = MUL_W'(mag_now);
				mul_b = MUL_W'(LAST_POS - pos_q);
			end
			MUL_RECIP: begin
				mul_a = MUL_W'(prod[FADE_NUM_W-1:0]);
				mul_b = RECIP_B;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	stg_mul u_mul (
		.clk    (clk),
		.en     (ctrl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	// Tone state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			inc_q      <= '0;
			rem_q      <= '0;
			first_q    <= 1'b1;
			pos_q      <= '0;
			from_div_q <= 1'b0;
		end else begin
			if (ctrl.take_start) begin
				inc_q <= req.data.phase_step;
				if (rem_q == '0) begin
					first_q <= 1'b1;
				end
			end
			if (ctrl.start_done) begin
				rem_q <= prod[MS_SHIFT +: REM_W];
			end
			if (ctrl.lookup) begin
				acc_q      <= phase_next;
				from_div_q <= 1'b0;
			end
			if (ctrl.div_step) begin
				from_div_q <= 1'b1;
			end
			if (ctrl.emit_sample) begin
				if (pos_q == LAST_POS) begin
					pos_q   <= '0;
					first_q <= 1'b0;
					if (ending) begin
						rem_q <= '0;
						acc_q <= '0;
					end else begin
						rem_q <= rem_q - REM_W'(BUFFER_SAMPLES);
					end
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	// Captured request duration and the sample looked up.
	always_ff @(posedge clk) begin
		if (ctrl.take_start) begin
			dur_q <= req.data.duration_ms;
		end
		if (ctrl.lookup) begin
			mag_q <= rom_abs[MAG_W-1:0];
			neg_q <= rom_val[SAMPLE_W-1];
		end
	end

	// Result register: filled by the sequencer, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit_sample || ctrl.emit_idle) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_sample) begin
			out_q.sample  <= neg_q ? -$signed({1'b0, mag_now}) : $signed({1'b0, mag_now});
			out_q.playing <= 1'b1;
			out_q.last    <= pos_q == LAST_POS;
		end else if (ctrl.emit_idle) begin
			out_q.sample  <= '0;
			out_q.playing <= 1'b0;
			out_q.last    <= 1'b1;
		end
	end

	assign req.ready = ctrl.req_ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/stg_checker.sv -----
// ----------------------------------------------------------------------------
// stg_checker: port-level checks of the sine tone generator
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire stg_pkg::res_t res_data
);

	import stg_pkg::*;

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// Every accepted request takes the request port out of its ready state.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request port ready right after a transfer");

	// The not-playing result is a lone silent item.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.playing |-> res_data.last && res_data.sample == '0)
		else $error("idle result is not a silent last item");

	// A faded or raw table sample never reaches the most negative code.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.playing |-> res_data.sample != 16'sh8000)
		else $error("sample out of range");

endmodule

bind sine_tone_generator_with_fades stg_checker u_stg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sine tone generator with fades
// Drives start and fill requests through the request stream and predicts
// every result: phase accumulation, sine table lookup, fade in on the first
// buffer and fade out on the last one. It runs under several idling patterns
// and one long result hold-off.
// ----------------------------------------------------------------------------

// Predicts the generator's results and compares them with what comes out.
class tone_scoreboard #(int FRAME_LEN = 64, int RATE = 48000, int MAX_PRINTED = 50);

	// Predicted generator state.
	logic signed [15:0] sine_table [256];
	logic [23:0]        phase_acc;
	logic [23:0]        phase_inc;
	logic [21:0]        samples_left;
	bit                 fade_in_pending;

	// Results owed by the block, oldest first.
	stg_pkg::res_t expected_samples [$];

	int mismatches;
	int starts;
	int fills;
	int idle_fills;
	int samples_checked;

	function new();
		real x;
		// Build the table from the sine itself, rounded to nearest.
		for (int k = 0; k < 256; k++) begin
			x = 32767.0 * $sin(2.0 * 3.141592653589793 * k / 256.0);
			sine_table[k] = 16'((x >= 0.0) ? $rtoi(x + 0.5) : -$rtoi(0.5 - x));
		end
		phase_acc       = '0;
		phase_inc       = '0;
		samples_left    = '0;
		fade_in_pending = 1'b1;
		mismatches      = 0;
		starts          = 0;
		fills           = 0;
		idle_fills      = 0;
		samples_checked = 0;
	endfunction

	// Updates the state for an accepted request and queues its results.
	function void note_request(stg_pkg::req_t r);
		int            s;
		bit            ending;
		stg_pkg::res_t item;
		if (r.req_type == stg_pkg::REQ_START) begin
			starts++;
			phase_inc = r.phase_step;
			if (samples_left == 0)
				fade_in_pending = 1'b1;
			samples_left = 22'((longint'(r.duration_ms) * RATE) / 1000);
		end else if (samples_left == 0) begin
			// A tone that has run out answers with a single idle result.
			fills++;
			idle_fills++;
			item.sample  = '0;
			item.playing = 1'b0;
			item.last    = 1'b1;
			expected_samples.push_back(item);
		end else begin
			fills++;
			ending = (samples_left <= FRAME_LEN);
			for (int i = 0; i < FRAME_LEN; i++) begin
				phase_acc = phase_acc + phase_inc;
				s = sine_table[phase_acc[23:16]];
				// Both fades truncate toward zero; fade out applies to the faded-in value.
				if (fade_in_pending)
					s = s * i / FRAME_LEN;
				if (ending)
					s = s * (FRAME_LEN - 1 - i) / FRAME_LEN;
				item.sample  = 16'(s);
				item.playing = 1'b1;
				item.last    = (i == FRAME_LEN - 1);
				expected_samples.push_back(item);
			end
			if (ending) begin
				samples_left = '0;
				phase_acc    = '0;
			end else begin
				samples_left = samples_left - 22'(FRAME_LEN);
			end
			fade_in_pending = 1'b0;
		end
	endfunction

	task report(string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Compares one accepted result with the oldest expectation.
	task check_result(stg_pkg::res_t got);
		stg_pkg::res_t want;
		if (expected_samples.size() == 0) begin
			report($sformatf("result with nothing expected: sample=%0d playing=%0b last=%0b",
				got.sample, got.playing, got.last));
		end else begin
			want = expected_samples.pop_front();
			samples_checked++;
			if (got.sample !== want.sample)
				report($sformatf("sample %0d, expected %0d", got.sample, want.sample));
			if (got.playing !== want.playing)
				report($sformatf("playing %0b, expected %0b", got.playing, want.playing));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b", got.last, want.last));
		end
	endtask

	function int pending_count();
		return expected_samples.size();
	endfunction

endclass

module testbench;

	import stg_pkg::*;

	localparam int FRAME_LEN       = 64;
	localparam int RATE            = 48000;
	localparam int TOTAL_ITEMS     = 460;
	localparam int DIRECTED_ITEMS  = 24;
	localparam int HOLD_OFF_CYCLES = 800;
	localparam int DRAIN_CYCLES    = 6 * FRAME_LEN + 16;
	localparam int CYCLE_LIMIT     = 1500000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	stg_stream_if #(.payload_t(req_t)) req_ch ();
	stg_stream_if #(.payload_t(res_t)) res_ch ();

	tone_scoreboard #(FRAME_LEN, RATE) sb;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int holds_requested    = 0;
	int items_sent         = 0;
	int cycle_count        = 0;

	sine_tone_generator_with_fades #(
		.BUFFER_SAMPLES(FRAME_LEN),
		.SAMPLE_RATE   (RATE)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.res   (res_ch)
	);

	always #5 clk = ~clk;

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.data);
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin : result_sink
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left    = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_requested) begin
				holds_served = holds_requested;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Offers one request, with random idle cycles first, and waits for its transfer.
	task automatic send_request(req_t item);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(item);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_start(logic [23:0] step, logic [15:0] dur);
		req_t item;
		item.req_type    = REQ_START;
		item.phase_step  = step;
		item.duration_ms = dur;
		send_request(item);
	endtask

	// The step and duration of a fill are don't-care, so they carry noise.
	task automatic send_fill();
		req_t item;
		item.req_type    = REQ_FILL;
		item.phase_step  = 24'($urandom);
		item.duration_ms = 16'($urandom);
		send_request(item);
	endtask

	// Fills until the tone ends, then one more fill that finds it idle.
	task automatic play_out();
		while (sb.samples_left != 0)
			send_fill();
		send_fill();
	endtask

	// Mostly complete tones with random content, the rest loose requests.
	task automatic random_scenario();
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 55) begin
			send_start(24'($urandom), 16'($urandom_range(1, 8)));
			if ($urandom_range(3) == 0) begin
				send_fill();
				send_start(24'($urandom), 16'($urandom_range(0, 4)));
			end
			play_out();
		end else if (pick < 70) begin
			// A long tone cut short by a restart that keeps its phase.
			send_start(24'($urandom), 16'($urandom));
			n = $urandom_range(1, 3);
			repeat (n) send_fill();
			send_start(24'($urandom), 16'($urandom_range(0, 3)));
			play_out();
		end else if (pick < 85) begin
			send_fill();
		end else if (pick < 93) begin
			send_start(24'($urandom), 16'h0000);
		end else begin
			send_start(24'($urandom), 16'($urandom));
		end
	endtask

	initial begin : stimulus
		sb = new();
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill straight out of reset, then a start of zero length.
		send_fill();
		send_start(24'h010000, 16'd0);
		send_fill();
		// A tone shorter than one buffer: fade in and fade out on the same buffer.
		send_start(24'hFFFFFF, 16'd1);
		play_out();
		// Two buffers: one faded in, one faded out.
		send_start(24'h020000, 16'd2);
		play_out();
		// The longest tone, restarted while playing, so no new fade in.
		send_start(24'h000001, 16'hFFFF);
		send_fill();
		send_fill();
		send_start(24'h123456, 16'd1);
		play_out();
		// A tone whose final buffer holds exactly one buffer's worth of samples.
		send_start(24'hAAAAAA, 16'd8);
		play_out();

		// Random part under four idling patterns.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 64;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 64;
				end
				default: begin
					sender_idle_pct    = 8;
					receiver_stall_pct = 8;
				end
			endcase
			if (phase == 0) begin
				// Results are held off while fills keep coming, so requests back up.
				holds_requested++;
				send_start(24'h0C0000, 16'd6);
				repeat (4) send_fill();
				play_out();
			end
			while (items_sent < DIRECTED_ITEMS + (phase + 1) * (TOTAL_ITEMS - DIRECTED_ITEMS) / 4)
				random_scenario();
		end
		req_ch.valid <= 1'b0;

		// Let every owed result transfer, then watch for strays.
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d tone starts, %0d fills (%0d on an idle generator).",
			items_sent, sb.starts, sb.fills, sb.idle_fills);
		$display("Compared %0d results under four idling patterns and one %0d-cycle hold-off.",
			sb.samples_checked, HOLD_OFF_CYCLES);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
